// File: src/rpj_pkg.sv
// Shared types, constants and helper functions for the RC pulse joint jog controller.
// Used by rpj_joint, rc_pulse_joint_jog_controller and rpj_checker; depends on nothing.
package rpj_pkg;

  // Field widths.
  localparam int PULSE_W = 12;
  localparam int ANGLE_W = 8;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 3;

  // Angle and speed limits.
  localparam int MAX_ANGLE_I = 180;
  localparam int MAX_STEP_I  = 15;
  localparam int SPEED_W     = $clog2(MAX_STEP_I + 1);

  localparam logic [ANGLE_W-1:0] MAX_ANGLE   = ANGLE_W'(MAX_ANGLE_I);
  localparam logic [ANGLE_W-1:0] MAX_STEP    = ANGLE_W'(MAX_STEP_I);
  localparam logic [ANGLE_W-1:0] JOINT_RESET = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0] GRIP_RESET  = '0;

  // Pulse scaling: (pulse - PULSE_MIN) * top / span, saturated to top.
  localparam int PULSE_MIN_I = 994;
  localparam int RATE_SPAN_I = 996;
  localparam int GRIP_SPAN_I = 999;

  localparam logic [PULSE_W-1:0] PULSE_MIN = PULSE_W'(PULSE_MIN_I);
  localparam logic [PULSE_W-1:0] RATE_SPAN = PULSE_W'(RATE_SPAN_I);
  localparam logic [PULSE_W-1:0] GRIP_SPAN = PULSE_W'(GRIP_SPAN_I);

  // Below the span the offset fits in SPAN_W bits. The quotient is taken as a
  // multiply by a rounded-up reciprocal; with a 20 bit shift the error term
  // stays below one unit for every offset under the span, so it is exact.
  localparam int SPAN_W    = $clog2(GRIP_SPAN_I);
  localparam int DIV_SHIFT = 20;
  localparam int MUL_W     = ANGLE_W + DIV_SHIFT - SPAN_W + 1;
  localparam int PROD_W    = SPAN_W + MUL_W;

  localparam longint RATE_MUL_L =
    ((longint'(MAX_STEP_I) << DIV_SHIFT) + longint'(RATE_SPAN_I) - 1) / longint'(RATE_SPAN_I);
  localparam longint GRIP_MUL_L =
    ((longint'(MAX_ANGLE_I) << DIV_SHIFT) + longint'(GRIP_SPAN_I) - 1) / longint'(GRIP_SPAN_I);

  localparam logic [MUL_W-1:0] RATE_MUL = MUL_W'(RATE_MUL_L);
  localparam logic [MUL_W-1:0] GRIP_MUL = MUL_W'(GRIP_MUL_L);

  // Operating modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_STOP   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    REG_MODE_STOP_BELOW  = 3'd0,
    REG_MODE_MANUAL_LOW  = 3'd1,
    REG_MODE_MANUAL_HIGH = 3'd2,
    REG_MODE_AUTO_ABOVE  = 3'd3,
    REG_JOG_LOW          = 3'd4,
    REG_JOG_HIGH         = 3'd5
  } cfg_reg_t;

  // One frame of receiver pulse widths.
  typedef struct packed {
    logic [PULSE_W-1:0] tower_pulse;
    logic [PULSE_W-1:0] link1_pulse;
    logic [PULSE_W-1:0] grip_pulse;
    logic [PULSE_W-1:0] link2_pulse;
    logic [PULSE_W-1:0] rate_pulse;
    logic [PULSE_W-1:0] mode_pulse;
  } frame_t;

  // One result: mode and servo angles after the frame.
  typedef struct packed {
    logic [MODE_W-1:0]  mode_now;
    logic [ANGLE_W-1:0] tower_angle;
    logic [ANGLE_W-1:0] link1_angle;
    logic [ANGLE_W-1:0] grip_angle;
    logic [ANGLE_W-1:0] link2_angle;
  } result_t;

  // Jog command for one joint.
  typedef struct packed {
    logic               up;
    logic               down;
    logic [SPEED_W-1:0] speed;
  } jog_cmd_t;

  // Scales a pulse width onto 0..top; zero at or below the minimum pulse.
  function automatic logic [ANGLE_W-1:0] scale_pulse(
    input logic [PULSE_W-1:0] pulse,
    input logic [PULSE_W-1:0] span,
    input logic [MUL_W-1:0]   mul,
    input logic [ANGLE_W-1:0] top
  );
    logic [PULSE_W-1:0] diff;
    logic [PROD_W-1:0]  prod;
    logic [ANGLE_W-1:0] res;
    diff = pulse - PULSE_MIN;
    prod = PROD_W'(diff[SPAN_W-1:0]) * PROD_W'(mul);
    if (pulse <= PULSE_MIN) begin
      res = '0;
    end else if (diff >= span) begin
      res = top;
    end else begin
      res = prod[DIV_SHIFT +: ANGLE_W];
    end
    return res;
  endfunction

endpackage

// File: src/rpj_joint.sv
// Jog update for one servo joint: step up, then step down, with saturation.
// Depends on rpj_pkg for widths, the angle limit and the jog command type.
module rpj_joint (
  input  logic [rpj_pkg::ANGLE_W-1:0] pos,
  input  rpj_pkg::jog_cmd_t           cmd,
  output logic [rpj_pkg::ANGLE_W-1:0] pos_next
);

  logic [rpj_pkg::ANGLE_W:0]   sum;
  logic [rpj_pkg::ANGLE_W-1:0] raised;
  logic [rpj_pkg::ANGLE_W-1:0] step;

  assign step = rpj_pkg::ANGLE_W'(cmd.speed);
  assign sum  = {1'b0, pos} + {1'b0, step};

  // Raise first, clamped to the top of the range; only from below the top.
  always_comb begin
    raised = pos;
    if (cmd.up && (pos < rpj_pkg::MAX_ANGLE)) begin
      if (sum > {1'b0, rpj_pkg::MAX_ANGLE}) begin
        raised = rpj_pkg::MAX_ANGLE;
      end else begin
        raised = sum[rpj_pkg::ANGLE_W-1:0];
      end
    end
  end

  // Then lower, clamped at zero.
  always_comb begin
    pos_next = raised;
    if (cmd.down && (raised != '0)) begin
      if (raised > step) begin
        pos_next = raised - step;
      end else begin
        pos_next = '0;
      end
    end
  end

endmodule

// File: src/rc_pulse_joint_jog_controller.sv
// Top level of the RC pulse joint jog controller: frame register, mode update,
// joint jog and gripper scaling, result register. Depends on rpj_pkg and rpj_joint.

// Each request on the frame channel carries six receiver pulse widths and
// produces exactly one result: the mode and the four servo angles after that
// frame. A frame is first held in an input register; the mode update, speed and
// gripper scaling (one reciprocal multiply each) and the three joint jogs are
// combinational from there into the result register, together with the state. The
// block takes one frame per clock cycle while results are taken; the held frame
// moves on once the result register is free; with the result stalled, one more
// frame is held and the frame channel then waits. Configuration writes complete in
// the cycle they are offered, indexes above five are ignored, and they are meant to
// be issued only while no frame is in flight.
module rc_pulse_joint_jog_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  output logic                          frame_ready,
  input  rpj_pkg::frame_t               frame,
  output logic                          result_valid,
  input  logic                          result_ready,
  output rpj_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rpj_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [rpj_pkg::PULSE_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [rpj_pkg::PULSE_W-1:0] mode_stop_below;
  logic [rpj_pkg::PULSE_W-1:0] mode_manual_low;
  logic [rpj_pkg::PULSE_W-1:0] mode_manual_high;
  logic [rpj_pkg::PULSE_W-1:0] mode_auto_above;
  logic [rpj_pkg::PULSE_W-1:0] jog_low;
  logic [rpj_pkg::PULSE_W-1:0] jog_high;

  // Controller state.
  rpj_pkg::mode_t              mode_reg;
  rpj_pkg::mode_t              mode_reg_next;
  logic [rpj_pkg::ANGLE_W-1:0] tower_pos;
  logic [rpj_pkg::ANGLE_W-1:0] link1_pos;
  logic [rpj_pkg::ANGLE_W-1:0] grip_pos;
  logic [rpj_pkg::ANGLE_W-1:0] link2_pos;
  logic [rpj_pkg::ANGLE_W-1:0] tower_pos_next;
  logic [rpj_pkg::ANGLE_W-1:0] link1_pos_next;
  logic [rpj_pkg::ANGLE_W-1:0] grip_pos_next;
  logic [rpj_pkg::ANGLE_W-1:0] link2_pos_next;

  // Input register.
  logic            hold_valid;
  rpj_pkg::frame_t hold;
  logic            advance;

  // Datapath signals.
  logic                        in_band;
  logic                        to_stop;
  logic                        to_auto;
  logic                        manual;
  logic [rpj_pkg::ANGLE_W-1:0] speed_wide;
  logic [rpj_pkg::ANGLE_W-1:0] grip_scaled;
  rpj_pkg::jog_cmd_t           tower_cmd;
  rpj_pkg::jog_cmd_t           link1_cmd;
  rpj_pkg::jog_cmd_t           link2_cmd;

  // Handshake: the held frame moves on when the result register is free.
  assign advance     = hold_valid && (!result_valid || result_ready);
  assign frame_ready = !hold_valid || advance;
  assign cfg_ready   = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_stop_below  <= rpj_pkg::PULSE_W'(1200);
      mode_manual_low  <= rpj_pkg::PULSE_W'(1400);
      mode_manual_high <= rpj_pkg::PULSE_W'(1600);
      mode_auto_above  <= rpj_pkg::PULSE_W'(1700);
      jog_low          <= rpj_pkg::PULSE_W'(1400);
      jog_high         <= rpj_pkg::PULSE_W'(1600);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rpj_pkg::REG_MODE_STOP_BELOW:  mode_stop_below  <= cfg_data;
        rpj_pkg::REG_MODE_MANUAL_LOW:  mode_manual_low  <= cfg_data;
        rpj_pkg::REG_MODE_MANUAL_HIGH: mode_manual_high <= cfg_data;
        rpj_pkg::REG_MODE_AUTO_ABOVE:  mode_auto_above  <= cfg_data;
        rpj_pkg::REG_JOG_LOW:          jog_low          <= cfg_data;
        rpj_pkg::REG_JOG_HIGH:         jog_high         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (frame_valid && frame_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      hold <= frame;
    end
  end

  // Mode switch decode.
  assign in_band = (hold.mode_pulse > mode_manual_low) && (hold.mode_pulse < mode_manual_high);
  assign to_stop = hold.mode_pulse < mode_stop_below;
  assign to_auto = hold.mode_pulse > mode_auto_above;

  // Mode next state; within each mode the later test wins.
  always_comb begin
    mode_reg_next = mode_reg;
    unique case (mode_reg)
      rpj_pkg::MODE_MANUAL: begin
        if (to_stop) mode_reg_next = rpj_pkg::MODE_STOP;
        if (to_auto) mode_reg_next = rpj_pkg::MODE_AUTO;
      end
      rpj_pkg::MODE_AUTO: begin
        if (in_band) mode_reg_next = rpj_pkg::MODE_MANUAL;
        if (to_stop) mode_reg_next = rpj_pkg::MODE_STOP;
      end
      default: begin
        if (in_band) mode_reg_next = rpj_pkg::MODE_MANUAL;
        if (to_auto) mode_reg_next = rpj_pkg::MODE_AUTO;
      end
    endcase
  end

  // Mode outputs: joints and gripper move only in manual mode.
  always_comb begin
    manual = (mode_reg_next == rpj_pkg::MODE_MANUAL);
  end

  // Speed and gripper scaling.
  assign speed_wide  = rpj_pkg::scale_pulse(hold.rate_pulse, rpj_pkg::RATE_SPAN,
                                            rpj_pkg::RATE_MUL, rpj_pkg::MAX_STEP);
  assign grip_scaled = rpj_pkg::scale_pulse(hold.grip_pulse, rpj_pkg::GRIP_SPAN,
                                            rpj_pkg::GRIP_MUL, rpj_pkg::MAX_ANGLE);
  assign grip_pos_next = manual ? grip_scaled : grip_pos;

  // Jog commands; the first link runs the opposite way to the stick.
  always_comb begin
    tower_cmd.speed = speed_wide[rpj_pkg::SPEED_W-1:0];
    tower_cmd.up    = manual && (hold.tower_pulse < jog_low);
    tower_cmd.down  = manual && (hold.tower_pulse > jog_high);
    link1_cmd.speed = speed_wide[rpj_pkg::SPEED_W-1:0];
    link1_cmd.up    = manual && (hold.link1_pulse > jog_high);
    link1_cmd.down  = manual && (hold.link1_pulse < jog_low);
    link2_cmd.speed = speed_wide[rpj_pkg::SPEED_W-1:0];
    link2_cmd.up    = manual && (hold.link2_pulse < jog_low);
    link2_cmd.down  = manual && (hold.link2_pulse > jog_high);
  end

  rpj_joint u_tower (
    .pos      (tower_pos),
    .cmd      (tower_cmd),
    .pos_next (tower_pos_next)
  );

  rpj_joint u_link1 (
    .pos      (link1_pos),
    .cmd      (link1_cmd),
    .pos_next (link1_pos_next)
  );

  rpj_joint u_link2 (
    .pos      (link2_pos),
    .cmd      (link2_cmd),
    .pos_next (link2_pos_next)
  );

  // State update, one frame per advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg  <= rpj_pkg::MODE_STOP;
      tower_pos <= rpj_pkg::JOINT_RESET;
      link1_pos <= rpj_pkg::JOINT_RESET;
      grip_pos  <= rpj_pkg::GRIP_RESET;
      link2_pos <= rpj_pkg::JOINT_RESET;
    end else if (advance) begin
      mode_reg  <= mode_reg_next;
      tower_pos <= tower_pos_next;
      link1_pos <= link1_pos_next;
      grip_pos  <= grip_pos_next;
      link2_pos <= link2_pos_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.mode_now    <= mode_reg_next;
      result.tower_angle <= tower_pos_next;
      result.link1_angle <= link1_pos_next;
      result.grip_angle  <= grip_pos_next;
      result.link2_angle <= link2_pos_next;
    end
  end

endmodule

// File: src/rpj_checker.sv
// Port-level checks for the RC pulse joint jog controller, bound to its top level.
// Depends on rpj_pkg and on the ports of rc_pulse_joint_jog_controller.
module rpj_checker (
  input logic             clk,
  input logic             rst,
  input logic             frame_valid,
  input logic             frame_ready,
  input logic             result_valid,
  input logic             result_ready,
  input rpj_pkg::result_t result
);

  // A stalled result holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // Every shown angle stays within the servo range.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.tower_angle <= rpj_pkg::MAX_ANGLE) &&
                     (result.link1_angle <= rpj_pkg::MAX_ANGLE) &&
                     (result.grip_angle <= rpj_pkg::MAX_ANGLE) &&
                     (result.link2_angle <= rpj_pkg::MAX_ANGLE))
    else $error("angle out of range");

  // Outside manual mode the gripper angle of a new result repeats the last one.
  a_grip_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready ##1 result_valid &&
    (result.mode_now != rpj_pkg::MODE_MANUAL) |-> $stable(result.grip_angle))
    else $error("gripper moved outside manual mode");

  // A frame is refused only while a result is waiting.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |-> result_valid && !result_ready)
    else $error("frame refused without a stalled result");

endmodule

bind rc_pulse_joint_jog_controller rpj_checker u_rpj_checker (
  .clk          (clk),
  .rst          (rst),
  .frame_valid  (frame_valid),
  .frame_ready  (frame_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// File: test/rpj_checker.sv
`timescale 1ns / 1ps
// Result checker for the RC pulse joint jog controller: tracks register writes,
// predicts mode and servo angles for every accepted frame and compares results.
// Depends on rpj_pkg for the frame, result, mode and register index types.
module rpj_scoreboard (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         frame_valid,
  input  logic                         frame_ready,
  input  rpj_pkg::frame_t              frame,
  input  logic                         result_valid,
  input  logic                         result_ready,
  input  rpj_pkg::result_t             result,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [rpj_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [rpj_pkg::PULSE_W-1:0]  cfg_data,
  output int                           errors,
  output int                           outstanding
);

  // Copy of the thresholds as last written.
  logic [rpj_pkg::PULSE_W-1:0] stop_below, manual_low, manual_high, auto_above;
  logic [rpj_pkg::PULSE_W-1:0] jog_low, jog_high;

  // Predicted arm state.
  rpj_pkg::mode_t              mode_q;
  logic [rpj_pkg::ANGLE_W-1:0] tower_q, link1_q, grip_q, link2_q;

  // Expected results, oldest first.
  rpj_pkg::result_t pending_results[$];

  // Maps a pulse width onto 0..top, truncating, zero at or below the minimum pulse.
  function automatic int scaled(int pulse, int top, int span);
    int v;
    if (pulse <= rpj_pkg::PULSE_MIN_I) return 0;
    v = (pulse - rpj_pkg::PULSE_MIN_I) * top / span;
    return (v > top) ? top : v;
  endfunction

  // Steps one joint up, then down, by the speed, saturating at both ends.
  function automatic logic [rpj_pkg::ANGLE_W-1:0] jogged(logic [rpj_pkg::ANGLE_W-1:0] angle,
                                                         logic up, logic down, int speed);
    int a;
    a = angle;
    if (a < rpj_pkg::MAX_ANGLE_I && up) begin
      a = a + speed;
      if (a > rpj_pkg::MAX_ANGLE_I) a = rpj_pkg::MAX_ANGLE_I;
    end
    if (a > 0 && down) a = (a > speed) ? a - speed : 0;
    return rpj_pkg::ANGLE_W'(a);
  endfunction

  // Advances the predicted state by one frame and queues the resulting angles.
  task automatic predict_frame(input rpj_pkg::frame_t f);
    logic             in_band, to_stop, to_auto;
    int               speed;
    rpj_pkg::result_t r;
    in_band = f.mode_pulse > manual_low && f.mode_pulse < manual_high;
    to_stop = f.mode_pulse < stop_below;
    to_auto = f.mode_pulse > auto_above;
    // Within each mode the later test takes priority.
    case (mode_q)
      rpj_pkg::MODE_MANUAL: begin
        if (to_stop) mode_q = rpj_pkg::MODE_STOP;
        if (to_auto) mode_q = rpj_pkg::MODE_AUTO;
      end
      rpj_pkg::MODE_AUTO: begin
        if (in_band) mode_q = rpj_pkg::MODE_MANUAL;
        if (to_stop) mode_q = rpj_pkg::MODE_STOP;
      end
      default: begin
        if (in_band) mode_q = rpj_pkg::MODE_MANUAL;
        if (to_auto) mode_q = rpj_pkg::MODE_AUTO;
      end
    endcase
    // Joints and gripper only move in manual mode; the first link is inverted.
    if (mode_q == rpj_pkg::MODE_MANUAL) begin
      speed   = scaled(f.rate_pulse, rpj_pkg::MAX_STEP_I, rpj_pkg::RATE_SPAN_I);
      tower_q = jogged(tower_q, f.tower_pulse < jog_low, f.tower_pulse > jog_high, speed);
      link1_q = jogged(link1_q, f.link1_pulse > jog_high, f.link1_pulse < jog_low, speed);
      link2_q = jogged(link2_q, f.link2_pulse < jog_low, f.link2_pulse > jog_high, speed);
      grip_q  = rpj_pkg::ANGLE_W'(scaled(f.grip_pulse, rpj_pkg::MAX_ANGLE_I,
                                         rpj_pkg::GRIP_SPAN_I));
    end
    r.mode_now    = mode_q;
    r.tower_angle = tower_q;
    r.link1_angle = link1_q;
    r.grip_angle  = grip_q;
    r.link2_angle = link2_q;
    pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Results are checked before the same edge's frame is predicted: a result
  // never leaves in the cycle its frame request is taken.
  always @(posedge clk) begin
    rpj_pkg::result_t want;
    if (rst) begin
      errors      = 0;
      stop_below  = rpj_pkg::PULSE_W'(1200);
      manual_low  = rpj_pkg::PULSE_W'(1400);
      manual_high = rpj_pkg::PULSE_W'(1600);
      auto_above  = rpj_pkg::PULSE_W'(1700);
      jog_low     = rpj_pkg::PULSE_W'(1400);
      jog_high    = rpj_pkg::PULSE_W'(1600);
      mode_q      = rpj_pkg::MODE_STOP;
      tower_q     = rpj_pkg::JOINT_RESET;
      link1_q     = rpj_pkg::JOINT_RESET;
      grip_q      = rpj_pkg::GRIP_RESET;
      link2_q     = rpj_pkg::JOINT_RESET;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (rpj_pkg::cfg_reg_t'(cfg_index))
          rpj_pkg::REG_MODE_STOP_BELOW:  stop_below  = cfg_data;
          rpj_pkg::REG_MODE_MANUAL_LOW:  manual_low  = cfg_data;
          rpj_pkg::REG_MODE_MANUAL_HIGH: manual_high = cfg_data;
          rpj_pkg::REG_MODE_AUTO_ABOVE:  auto_above  = cfg_data;
          rpj_pkg::REG_JOG_LOW:          jog_low     = cfg_data;
          rpj_pkg::REG_JOG_HIGH:         jog_high    = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $error("result request with no frame outstanding: %p", result);
        end else begin
          want = pending_results.pop_front();
          check_field("mode_now", want.mode_now, result.mode_now);
          check_field("tower_angle", want.tower_angle, result.tower_angle);
          check_field("link1_angle", want.link1_angle, result.link1_angle);
          check_field("grip_angle", want.grip_angle, result.grip_angle);
          check_field("link2_angle", want.link2_angle, result.link2_angle);
        end
      end
      if (frame_valid && frame_ready) predict_frame(frame);
    end
    outstanding = pending_results.size();
  end

endmodule

// File: test/rc_pulse_joint_jog_controller_test.sv
`timescale 1ns / 1ps
// Testbench top for rc_pulse_joint_jog_controller: clock, reset, frame and
// register write stimulus, result back-pressure and the verdict. Uses rpj_pkg and rpj_scoreboard.
module rc_pulse_joint_jog_controller_test;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 60;
  localparam int PULSE_TOP  = (1 << rpj_pkg::PULSE_W) - 1;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [rpj_pkg::INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [rpj_pkg::INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         frame_valid  = 1'b0;
  rpj_pkg::frame_t              frame        = '0;
  logic                         result_ready = 1'b0;
  logic                         cfg_valid    = 1'b0;
  logic [rpj_pkg::INDEX_W-1:0]  cfg_index    = '0;
  logic [rpj_pkg::PULSE_W-1:0]  cfg_data     = '0;
  logic                         frame_ready;
  logic                         result_valid;
  rpj_pkg::result_t             result;
  logic                         cfg_ready;

  int errors;
  int outstanding;

  // Idle percentages per side and the long receiver hold-off request.
  int frame_gap_pct = 0;
  int ready_gap_pct = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  int stall_left    = 0;
  int idle_cycles   = 0;

  // Thresholds as last written, used only to aim pulses near the edges and into the manual band.
  int thresholds[6] = '{1200, 1400, 1600, 1700, 1400, 1600};

  rc_pulse_joint_jog_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rpj_scoreboard jog_check (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result back-pressure: random stall bursts, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (hold_req && !hold_done) begin
      result_ready <= 1'b0;
      stall_left   <= LONG_HOLD - 1;
      hold_done    <= 1'b1;
    end else if ($urandom_range(0, 99) < ready_gap_pct) begin
      result_ready <= 1'b0;
      stall_left   <= $urandom_range(0, 8);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which no request of any kind is taken.
  always @(posedge clk) begin
    if (rst || (frame_valid && frame_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL rc_pulse_joint_jog_controller");
      $finish;
    end
  end

  function automatic logic [rpj_pkg::PULSE_W-1:0] fit(int v);
    if (v < 0) v = 0;
    if (v > PULSE_TOP) v = PULSE_TOP;
    return rpj_pkg::PULSE_W'(v);
  endfunction

  function automatic rpj_pkg::frame_t make_frame(int tower, int link1, int grip, int link2,
                                                 int rate, int mode);
    rpj_pkg::frame_t f;
    f.tower_pulse = fit(tower);
    f.link1_pulse = fit(link1);
    f.grip_pulse  = fit(grip);
    f.link2_pulse = fit(link2);
    f.rate_pulse  = fit(rate);
    f.mode_pulse  = fit(mode);
    return f;
  endfunction

  // Mostly servo-range pulses, with extremes and values at and beside the lo and hi thresholds.
  function automatic logic [rpj_pkg::PULSE_W-1:0] pick_pulse(int lo, int hi);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? fit(PULSE_TOP) : fit(0);
      1:       return fit(lo + int'($urandom_range(0, 2)) - 1);
      2:       return fit(hi + int'($urandom_range(0, 2)) - 1);
      8, 9:    return fit($urandom_range(0, PULSE_TOP));
      default: return fit($urandom_range(900, 2100));
    endcase
  endfunction

  // Mode pulses lean on the manual band so that the joints get to move.
  function automatic logic [rpj_pkg::PULSE_W-1:0] pick_mode();
    int lo;
    int hi;
    lo = thresholds[rpj_pkg::REG_MODE_MANUAL_LOW];
    hi = thresholds[rpj_pkg::REG_MODE_MANUAL_HIGH];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (hi - lo >= 2) return fit($urandom_range(lo + 1, hi - 1));
        return fit($urandom_range(0, PULSE_TOP));
      end
      4: return fit(thresholds[rpj_pkg::REG_MODE_STOP_BELOW] + int'($urandom_range(0, 2)) - 1);
      5: return fit(lo + int'($urandom_range(0, 2)) - 1);
      6: return fit(hi + int'($urandom_range(0, 2)) - 1);
      7: return fit(thresholds[rpj_pkg::REG_MODE_AUTO_ABOVE] + int'($urandom_range(0, 2)) - 1);
      8: return $urandom_range(0, 1) ? fit(PULSE_TOP) : fit(0);
      default: return fit($urandom_range(0, PULSE_TOP));
    endcase
  endfunction

  function automatic rpj_pkg::frame_t random_frame();
    rpj_pkg::frame_t f;
    int              jlo;
    int              jhi;
    jlo = thresholds[rpj_pkg::REG_JOG_LOW];
    jhi = thresholds[rpj_pkg::REG_JOG_HIGH];
    f.tower_pulse = pick_pulse(jlo, jhi);
    f.link1_pulse = pick_pulse(jlo, jhi);
    f.grip_pulse  = pick_pulse(rpj_pkg::PULSE_MIN_I,
                               rpj_pkg::PULSE_MIN_I + rpj_pkg::GRIP_SPAN_I);
    f.link2_pulse = pick_pulse(jlo, jhi);
    f.rate_pulse  = pick_pulse(rpj_pkg::PULSE_MIN_I,
                               rpj_pkg::PULSE_MIN_I + rpj_pkg::RATE_SPAN_I);
    f.mode_pulse  = pick_mode();
    return f;
  endfunction

  // Offers one frame request, after a random gap, and returns at the edge that takes it.
  task automatic send_frame(input rpj_pkg::frame_t f);
    int gap;
    gap = ($urandom_range(0, 99) < frame_gap_pct) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= f;
    @(posedge clk);
    while (!frame_ready) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_frame(random_frame());
  endtask

  // Stops offering frames and waits until every result has come back.
  task automatic drain();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Leaves the write request raised; the caller lowers it after the last write.
  task automatic write_reg(input logic [rpj_pkg::INDEX_W-1:0] index, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= fit(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index <= rpj_pkg::REG_JOG_HIGH) thresholds[index] = data;
  endtask

  task automatic load_config(input int stop_below, input int manual_low, input int manual_high,
                             input int auto_above, input int jog_low, input int jog_high);
    write_reg(rpj_pkg::REG_MODE_STOP_BELOW, stop_below);
    write_reg(rpj_pkg::REG_MODE_MANUAL_LOW, manual_low);
    write_reg(rpj_pkg::REG_MODE_MANUAL_HIGH, manual_high);
    write_reg(rpj_pkg::REG_MODE_AUTO_ABOVE, auto_above);
    write_reg(rpj_pkg::REG_JOG_LOW, jog_low);
    write_reg(rpj_pkg::REG_JOG_HIGH, jog_high);
    // A write past the last register goes last, so a stray hit would show.
    write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
              $urandom_range(0, PULSE_TOP));
    cfg_valid <= 1'b0;
  endtask

  // Ordered thresholds with random spacing, kept inside the pulse range.
  task automatic load_random_config();
    int stop_below, manual_low, manual_high, auto_above, jog_low;
    stop_below  = $urandom_range(900, 1400);
    manual_low  = stop_below + $urandom_range(0, 200);
    manual_high = manual_low + $urandom_range(2, 400);
    auto_above  = manual_high + $urandom_range(0, 200);
    jog_low     = $urandom_range(1000, 1500);
    load_config(stop_below, manual_low, manual_high, auto_above, jog_low,
                jog_low + $urandom_range(0, 300));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the reset thresholds.
    frame_gap_pct = 30;
    ready_gap_pct = 30;
    // Mode pulses in the gaps hold stop; a stop pulse in stop changes nothing.
    send_frame(make_frame(1500, 1500, 1500, 1500, 1500, 1300));
    send_frame(make_frame(0, 4095, 0, 4095, 4095, 0));
    // Stop to auto, then auto to manual with zero speed and gripper closed.
    send_frame(make_frame(0, 4095, 4095, 0, 4095, 4095));
    send_frame(make_frame(1500, 1500, 994, 1500, 994, 1500));
    // Just past the minimum pulse the speed and gripper still scale to zero.
    send_frame(make_frame(1399, 1601, 995, 1399, 995, 1650));
    // Full speed drives all joints up until they saturate at the top.
    repeat (3) send_frame(make_frame(0, 4095, 1993, 0, 1990, 1401));
    repeat (4) send_frame(make_frame(0, 4095, 4095, 0, 4095, 1599));
    // Sticks sitting exactly on the jog thresholds do not move.
    send_frame(make_frame(1400, 1600, 1992, 1600, 1989, 1500));
    // Manual to stop, a pulse on the stop threshold holds, then back to manual.
    send_frame(make_frame(4095, 0, 4095, 4095, 4095, 1199));
    send_frame(make_frame(4095, 0, 4095, 4095, 4095, 1200));
    send_frame(make_frame(1500, 1500, 1500, 1500, 1500, 1401));
    // Manual to auto, a pulse on the auto threshold holds, then auto to manual.
    send_frame(make_frame(0, 0, 0, 0, 4095, 1701));
    send_frame(make_frame(0, 0, 0, 0, 4095, 1700));
    send_frame(make_frame(4095, 0, 1000, 4095, 1989, 1599));
    // Joints stepping down at full speed, then no speed at all.
    send_frame(make_frame(1601, 1399, 0, 1601, 4095, 1500));
    send_frame(make_frame(4095, 0, 4095, 4095, 0, 1500));

    // All thresholds at zero, then all at the top of the range.
    drain();
    load_config(0, 0, 0, 0, 0, 0);
    frame_gap_pct = 20;
    ready_gap_pct = 20;
    run_random(100);
    drain();
    load_config(4095, 4095, 4095, 4095, 4095, 4095);
    run_random(100);

    // Overlapping bands: later tests win, and sticks can jog both ways at once.
    drain();
    load_config(2048, 0, 4095, 1024, 3000, 1000);
    frame_gap_pct = 0;
    ready_gap_pct = 0;
    run_random(150);

    drain();
    load_random_config();
    frame_gap_pct = 30;
    ready_gap_pct = 30;
    run_random(125);
    drain();
    load_random_config();
    run_random(125);

    // Back at the reset thresholds, including one long result hold-off.
    drain();
    load_config(1200, 1400, 1600, 1700, 1400, 1600);
    frame_gap_pct = 20;
    ready_gap_pct = 20;
    run_random(150);
    frame_gap_pct = 0;
    hold_req      = 1'b1;
    run_random(100);
    frame_gap_pct = 50;
    ready_gap_pct = 50;
    run_random(100);
    // Last stretch without any idling.
    frame_gap_pct = 0;
    ready_gap_pct = 0;
    run_random(100);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS rc_pulse_joint_jog_controller");
    end else begin
      $display("FAIL rc_pulse_joint_jog_controller");
    end
    $finish;
  end

endmodule
